/* hw/rtl/addr_txt_pkg.sv */
package addr_txt_pkg;

    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 48;
    localparam int GIDX_W   = 3;
    localparam int DCNT_W   = 2;
    localparam int GVAL_W   = 10;
    localparam int BYTE_W   = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3a;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_F  = 8'h46;

    localparam logic [GIDX_W-1:0] IPV4_SEPS       = 3'd3;
    localparam logic [GIDX_W-1:0] MAC_SEPS        = 3'd5;
    localparam logic [DCNT_W-1:0] IPV4_MAX_DIGITS = 2'd3;
    localparam logic [DCNT_W-1:0] MAC_DIGITS      = 2'd2;
    localparam logic [GVAL_W-1:0] GROUP_MAX       = 10'd255;

    typedef enum logic {
        MODE_IPV4 = 1'b0,
        MODE_MAC  = 1'b1
    } t_mode;

    typedef struct packed {
        logic [GIDX_W-1:0] group_index;
        logic [DCNT_W-1:0] digit_count;
        logic [GVAL_W-1:0] group_value;
        logic [ADDR_W-1:0] address_accum;
        logic              error_seen;
    } t_parse_state;

    typedef struct packed {
        logic              done;
        logic              valid_res;
        logic [ADDR_W-1:0] address;
    } t_parse_result;

    localparam t_parse_state PARSE_CLEAR = '0;

endpackage

/* hw/rtl/address_text_parser.sv */
// Address text parser.
// The slave stream carries one character per transaction in tdata. Characters
// build up either a dotted-decimal IPv4 address or a colon-separated hex MAC
// address, as chosen by the mode register. A zero character ends the string
// and produces exactly one master transaction: tuser is the valid flag and
// tdata the 48-bit address, which is zero when the flag is clear.
// Writing the mode register restarts the parse; write it only while idle (not
// enforced). One character is accepted every cycle. The result of a terminator
// appears on the master side in the cycle after it is accepted: the parse
// state and the result sit in registers with one short decode step between
// them. The result register also acts as the output buffer, so the slave side
// keeps accepting while a result is pending and the receiver takes it. When
// the receiver stalls with a result held, the slave side deasserts tready
// until that result is taken, and the held transaction does not change.
// Reset selects IPv4 mode, clears the parse state and empties the output.
module address_text_parser
    import addr_txt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // char_in
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [47:0]       o_m_axis_tdata,   // address
    output logic              o_m_axis_tuser    // valid_res
);

    t_mode             r_mode;
    t_parse_state      r_state;
    t_parse_state      n_state;
    t_parse_result     n_result;
    logic              r_out_valid;
    logic              r_out_flag;
    logic [ADDR_W-1:0] r_out_addr;
    logic              in_fire;

    addr_txt_step u_step (
        .i_mode   (r_mode),
        .i_state  (r_state),
        .i_char   (i_s_axis_tdata),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IPV4;
            r_state     <= PARSE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode  <= t_mode'(i_cfg_wdata);
                r_state <= PARSE_CLEAR;
            end else if (in_fire) begin
                r_state <= n_state;
            end
            if (in_fire && n_result.done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_result.done) begin
            r_out_flag <= n_result.valid_res;
            r_out_addr <= n_result.address;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_addr;
    assign o_m_axis_tuser  = r_out_flag;

endmodule

/* hw/rtl/addr_txt_step.sv */
module addr_txt_step
    import addr_txt_pkg::*;
(
    input  t_mode              i_mode,
    input  t_parse_state       i_state,
    input  logic [CHAR_W-1:0]  i_char,
    output t_parse_state       o_state,
    output t_parse_result      o_result
);

    logic              is_dec;
    logic              is_hex;
    logic [3:0]        digit_val;
    logic [BYTE_W-1:0] group_byte;
    logic [5:0]        shift_amt;
    logic [ADDR_W-1:0] placed;
    logic              ok;

    always_comb begin
        is_dec    = 1'b0;
        is_hex    = 1'b0;
        digit_val = '0;
        if (i_char inside {[CHAR_ZERO:CHAR_NINE]}) begin
            is_dec    = 1'b1;
            is_hex    = 1'b1;
            digit_val = 4'(i_char - CHAR_ZERO);
        end else if (i_char inside {[CHAR_LC_A:CHAR_LC_F]}) begin
            is_hex    = 1'b1;
            digit_val = 4'(i_char - CHAR_LC_A + 8'd10);
        end else if (i_char inside {[CHAR_UC_A:CHAR_UC_F]}) begin
            is_hex    = 1'b1;
            digit_val = 4'(i_char - CHAR_UC_A + 8'd10);
        end
    end

    assign group_byte = i_state.group_value[BYTE_W-1:0];

    always_comb begin
        if (i_mode == MODE_MAC) begin
            shift_amt = {i_state.group_index, 3'b000};
        end else begin
            shift_amt = {3'(IPV4_SEPS - i_state.group_index), 3'b000};
        end
        placed = {{(ADDR_W-BYTE_W){1'b0}}, group_byte} << shift_amt;
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        ok       = 1'b0;
        if (i_char == CHAR_NUL) begin
            o_result.done = 1'b1;
            ok = !i_state.error_seen && (i_state.group_value <= GROUP_MAX);
            if (i_mode == MODE_MAC) begin
                ok = ok && (i_state.group_index == MAC_SEPS)
                        && (i_state.digit_count == MAC_DIGITS);
                o_result.address = i_state.address_accum
                    | ({{(ADDR_W-BYTE_W){1'b0}}, group_byte} << (MAC_SEPS * BYTE_W));
            end else begin
                ok = ok && (i_state.group_index == IPV4_SEPS);
                o_result.address = i_state.address_accum
                    | {{(ADDR_W-BYTE_W){1'b0}}, group_byte};
            end
            o_result.valid_res = ok;
            if (!ok) begin
                o_result.address = '0;
            end
            o_state = PARSE_CLEAR;
        end else if (!i_state.error_seen) begin
            if (i_mode == MODE_MAC) begin
                if (is_hex) begin
                    if (i_state.digit_count >= MAC_DIGITS) begin
                        o_state.error_seen = 1'b1;
                    end else begin
                        o_state.group_value = {i_state.group_value[GVAL_W-5:0], digit_val};
                        o_state.digit_count = i_state.digit_count + 2'd1;
                    end
                end else if (i_char == CHAR_COLON) begin
                    if (i_state.group_index >= MAC_SEPS
                            || i_state.group_value > GROUP_MAX) begin
                        o_state.error_seen = 1'b1;
                    end else begin
                        o_state.address_accum = i_state.address_accum | placed;
                        o_state.group_index   = i_state.group_index + 3'd1;
                        o_state.digit_count   = '0;
                        o_state.group_value   = '0;
                    end
                end else begin
                    o_state.error_seen = 1'b1;
                end
            end else begin
                if (is_dec) begin
                    if (i_state.digit_count >= IPV4_MAX_DIGITS) begin
                        o_state.error_seen = 1'b1;
                    end else begin
                        o_state.group_value = GVAL_W'(i_state.group_value * 4'd10)
                                            + {{(GVAL_W-4){1'b0}}, digit_val};
                        o_state.digit_count = i_state.digit_count + 2'd1;
                    end
                end else if (i_char == CHAR_DOT) begin
                    if (i_state.group_index >= IPV4_SEPS
                            || i_state.group_value > GROUP_MAX) begin
                        o_state.error_seen = 1'b1;
                    end else begin
                        o_state.address_accum = i_state.address_accum | placed;
                        o_state.group_index   = i_state.group_index + 3'd1;
                        o_state.digit_count   = '0;
                        o_state.group_value   = '0;
                    end
                end else begin
                    o_state.error_seen = 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/addr_txt_chk.sv */
module addr_txt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // A rejected string always reports a zero address.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == 48'd0))
        else $error("invalid result carries a non-zero address");

    // A new result only follows an accepted terminator.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |->
            $past(i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tdata == 8'd0)))
        else $error("result without a terminator");

    // A held result blocks the input side.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while a result is stalled");

    // A stalled result stays unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind address_text_parser addr_txt_chk u_addr_txt_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
